// ===== src/xylm_pkg.sv =====
// package for the xy link metropolis step block
// grid sizes, angle width, register indexes and opcodes; no dependencies
`default_nettype none
package xylm_pkg;
    localparam int GRID_ROWS  = 64;
    localparam int GRID_COLS  = 64;
    localparam int ANGLE_BITS = 16;
    localparam int ROW_BITS   = $clog2(GRID_ROWS);
    localparam int COL_BITS   = $clog2(GRID_COLS);
    localparam int CELL_BITS  = ROW_BITS + COL_BITS;
    localparam int CELLS      = GRID_ROWS * GRID_COLS;

    localparam logic [1:0] REG_BETA = 2'd0;
    localparam logic [1:0] REG_STEP = 2'd1;
    localparam logic [1:0] REG_FILL = 2'd2;
    localparam logic [1:0] REG_TOL  = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRIAL = 1'b1;
endpackage
`default_nettype wire

// ===== src/xylm_cos.sv =====
// quarter-wave polynomial cosine, one horner step per cycle on a shared multiplier
// depends on xylm_pkg for the angle width
`default_nettype none
module xylm_cos (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [xylm_pkg::ANGLE_BITS-1:0]     i_angle,
    output logic                                     o_done,
    output logic signed [15:0]                       o_cos
);
    typedef enum logic [2:0] {S_IDLE, S_SQ, S_H1, S_H2, S_H3, S_H4} t_state;
    t_state r_state;
    logic [15:0] r_u;
    logic [15:0] r_w;
    logic signed [17:0] r_p;
    logic r_neg;
    logic [15:0] a16;
    logic [13:0] rem;
    logic signed [35:0] prod;
    logic signed [17:0] pw;

    // rescale to 16 bits
    always_comb begin
        if (xylm_pkg::ANGLE_BITS >= 16)
            a16 = 16'(i_angle >> (xylm_pkg::ANGLE_BITS - 16));
        else
            a16 = 16'({i_angle, 16'h0} >> xylm_pkg::ANGLE_BITS);
        rem = a16[13:0];
    end

    // shared multiplier: u*u in the square step, p*w otherwise
    always_comb begin
        if (r_state == S_SQ)
            prod = $signed({2'b0, r_u}) * $signed({20'b0, r_u});
        else
            prod = r_p * $signed({20'b0, r_w});
        pw = 18'(prod >>> 14);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_u   <= a16[14] ? 16'(17'd16384 - {3'b0, rem}) : {2'b0, rem};
                        r_neg <= a16[15] ^ a16[14];
                        r_p   <= 18'sd15;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_w <= 16'(prod >>> 14);
                    r_state <= S_H1;
                end
                S_H1: begin r_p <= 18'sd342 - pw;   r_state <= S_H2; end
                S_H2: begin r_p <= 18'sd4156 - pw;  r_state <= S_H3; end
                S_H3: begin r_p <= 18'sd20213 - pw; r_state <= S_H4; end
                S_H4: begin
                    o_cos <= (18'sd16384 - pw < 0) ? 16'sd0 :
                        (r_neg ? -16'(18'sd16384 - pw) : 16'(18'sd16384 - pw));
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/xy_link_metropolis_step_top.sv =====
// top level of the xy link metropolis step block
// link memories, sequencer and acceptance math; uses xylm_pkg and xylm_cos
// sequence: a load is written at its accepting edge and gives no result; a trial runs link
// reads, eight cosines on the cosine unit, an exponential with reciprocal division if needed,
// up to 4 writebacks, charge reads and up to 6 match steps, then raises its result strobe
// throughput: loads every cycle while idle; busy stays high until the strobe cycle,
// no output stall
// reset: config registers return to defaults and the sequencer to idle, links are undefined until loaded
`default_nettype none
module xy_link_metropolis_step_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_opcode,
    input  wire logic [5:0]  i_row,
    input  wire logic [5:0]  i_col,
    input  wire logic signed [15:0] i_east_angle,
    input  wire logic signed [15:0] i_south_angle,
    input  wire logic [15:0] i_step_random,
    input  wire logic [15:0] i_accept_random,
    output logic             o_valid,
    output logic             o_accepted,
    output logic signed [2:0] o_charge,
    output logic             o_charge_valid
);
    localparam int AB = xylm_pkg::ANGLE_BITS;
    localparam int RB = xylm_pkg::ROW_BITS;
    localparam int CB = xylm_pkg::COL_BITS;
    localparam int NB = xylm_pkg::CELL_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_PHI, S_RD, S_RDW, S_COS, S_COSW, S_DE, S_Y, S_T, S_G,
        S_EXPM, S_DIV, S_EXPE, S_WB, S_CRD, S_CRDW, S_CH, S_MATCH, S_OUT
    } t_state;
    t_state r_state;

    logic [AB-1:0] r_east [xylm_pkg::CELLS];
    logic [AB-1:0] r_south [xylm_pkg::CELLS];

    logic [15:0] r_beta, r_step, r_fill, r_tol;
    logic [RB-1:0] r_r;
    logic [CB-1:0] r_c;
    logic [15:0] r_u1, r_u2;
    logic [AB-1:0] r_ph;
    logic [AB-1:0] r_old [4];
    logic [2:0] r_idx;
    logic [1:0] r_ri;
    logic signed [19:0] r_de;
    logic [33:0] r_y;
    logic [47:0] r_t;
    logic [4:0] r_n;
    logic [16:0] r_g;
    logic [16:0] r_p;
    logic [2:0] r_k;
    logic [33:0] r_num;
    logic r_acc;
    logic [AB-1:0] r_rd_e, r_rd_s;
    logic signed [AB+2:0] r_phase;
    logic signed [AB+34:0] r_ch;
    logic [2:0] r_mi;

    logic cos_start, cos_done;
    logic signed [15:0] cos_val;
    logic [AB-1:0] cos_in;

    // address for each of the four links and the two charge-only links
    logic [RB-1:0] rn, rs;
    logic [CB-1:0] cw, ce;
    logic [NB-1:0] a_here, a_w, a_n, a_s, a_e;
    always_comb begin
        rn = (r_r == '0) ? RB'(xylm_pkg::GRID_ROWS - 1) : r_r - 1'b1;
        rs = (r_r == RB'(xylm_pkg::GRID_ROWS - 1)) ? '0 : r_r + 1'b1;
        cw = (r_c == '0) ? CB'(xylm_pkg::GRID_COLS - 1) : r_c - 1'b1;
        ce = (r_c == CB'(xylm_pkg::GRID_COLS - 1)) ? '0 : r_c + 1'b1;
        a_here = {r_r, r_c};
        a_w = {r_r, cw};
        a_n = {rn, r_c};
        a_s = {rs, r_c};
        a_e = {r_r, ce};
    end

    // new value of a link given the stored old value
    function automatic logic [AB-1:0] new_link(input logic [1:0] i, input logic [AB-1:0] o,
                                               input logic [AB-1:0] ph);
        new_link = (i < 2'd2) ? o - ph : o + ph;
    endfunction

    // cosine argument: old links for idx 0..3, new links for idx 4..7
    assign cos_in = r_idx[2] ? new_link(r_idx[1:0], r_old[r_idx[1:0]], r_ph)
                             : r_old[r_idx[1:0]];

    xylm_cos u_cos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cos_start), .i_angle(cos_in),
        .o_done(cos_done), .o_cos(cos_val)
    );
    assign cos_start = (r_state == S_COS);

    // input rescale
    function automatic logic [AB-1:0] from16(input logic [15:0] v);
        if (AB >= 16) from16 = AB'({v, 8'b0} >> (24 - AB) );
        else from16 = AB'(v >> (16 - AB));
    endfunction

    function automatic logic signed [AB+2:0] sx(input logic [AB-1:0] a);
        sx = (AB+3)'($signed(a));
    endfunction

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= 16'd2560;
            r_step <= 16'd6554;
            r_fill <= 16'd240;
            r_tol  <= 16'd66;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                xylm_pkg::REG_BETA: r_beta <= i_cfg_data;
                xylm_pkg::REG_STEP: r_step <= i_cfg_data;
                xylm_pkg::REG_FILL: r_fill <= i_cfg_data;
                xylm_pkg::REG_TOL:  r_tol  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memory write and registered read
    logic mem_we;
    logic [NB-1:0] mem_wa, mem_ra;
    logic [AB-1:0] mem_we_e, mem_we_s;
    logic mem_we_en_e, mem_we_en_s;
    logic [AB-1:0] rd_e, rd_s;
    always_comb begin
        mem_we = 1'b0; mem_we_en_e = 1'b0; mem_we_en_s = 1'b0;
        mem_wa = a_here; mem_we_e = '0; mem_we_s = '0; mem_ra = a_here;
        if (i_rst_n && r_state == S_IDLE && start && i_opcode == xylm_pkg::OP_LOAD) begin
            mem_we = 1'b1; mem_we_en_e = 1'b1; mem_we_en_s = 1'b1;
            mem_wa = {i_row[RB-1:0], i_col[CB-1:0]};
            mem_we_e = from16(i_east_angle);
            mem_we_s = from16(i_south_angle);
        end else if (r_state == S_WB && r_acc) begin
            mem_we = 1'b1;
            mem_we_e = new_link(r_idx[1:0], r_old[r_idx[1:0]], r_ph);
            mem_we_s = mem_we_e;
            unique case (r_idx[1:0])
                2'd0: begin mem_wa = a_here; mem_we_en_e = 1'b1; end
                2'd1: begin mem_wa = a_here; mem_we_en_s = 1'b1; end
                2'd2: begin mem_wa = a_w; mem_we_en_e = 1'b1; end
                default: begin mem_wa = a_n; mem_we_en_s = 1'b1; end
            endcase
        end
        if (r_state == S_RD) begin
            unique case (r_ri)
                2'd2: mem_ra = a_w;
                2'd3: mem_ra = a_n;
                default: mem_ra = a_here;
            endcase
        end else if (r_state == S_CRD) begin
            mem_ra = (r_ri == 2'd0) ? a_here : ((r_ri == 2'd1) ? a_s : a_e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && mem_we_en_e) r_east[mem_wa] <= mem_we_e;
        if (mem_we && mem_we_en_s) r_south[mem_wa] <= mem_we_s;
        rd_e <= r_east[mem_ra];
        rd_s <= r_south[mem_ra];
    end

    // reciprocal of k scaled by 2^20, exact floor for dividends below 2^17
    logic [20:0] recip_k;
    always_comb begin
        unique case (r_k)
            3'd1:    recip_k = 21'd1048576;
            3'd2:    recip_k = 21'd524288;
            3'd3:    recip_k = 21'd349526;
            3'd4:    recip_k = 21'd262144;
            3'd5:    recip_k = 21'd209716;
            3'd6:    recip_k = 21'd174763;
            default: recip_k = '0;
        endcase
    end

    // shared multiplier inputs
    logic [33:0] mul_a;
    logic [20:0] mul_b;
    logic [54:0] mprod;
    always_comb begin
        unique case (r_state)
            S_Y:    begin mul_a = {18'b0, r_beta};        mul_b = {1'b0, r_de}; end
            S_T:    begin mul_a = r_y;                    mul_b = 21'd47274; end
            S_G:    begin mul_a = {18'b0, r_t[21:6]};     mul_b = 21'd45426; end
            S_EXPM: begin mul_a = {17'b0, r_g};           mul_b = {4'b0, r_p}; end
            S_DIV:  begin mul_a = {16'b0, r_num[33:16]};  mul_b = recip_k; end
            default: begin mul_a = '0;                    mul_b = '0; end
        endcase
        mprod = {21'b0, mul_a} * {34'b0, mul_b};
    end

    // charge match
    logic signed [AB+34:0] dlt, tolw;
    always_comb begin
        dlt = r_ch - ((AB+35)'($signed({1'b0, r_mi})) - (AB+35)'(2)) * ((AB+35)'(1) << (AB+16));
        tolw = (AB+35)'({1'b0, r_tol}) <<< AB;
    end

    logic signed [33:0] sprod;
    assign sprod = ($signed({1'b0, r_u1}) - 34'sd32768) * $signed({18'b0, r_step});

    assign busy = (r_state != S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_r <= i_row[RB-1:0];
                        r_c <= i_col[CB-1:0];
                        r_u1 <= i_step_random;
                        r_u2 <= i_accept_random;
                        if (i_opcode == xylm_pkg::OP_TRIAL) r_state <= S_PHI;
                    end
                end
                S_PHI: begin
                    r_ph <= AB'(((sprod + 34'sd2147483648) >>> (32 - AB))
                                - (34'sd1 <<< (AB - 1)));
                    r_ri <= 2'd0;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    r_old[r_ri] <= r_ri[0] ? rd_s : rd_e;
                    r_ri <= r_ri + 1'b1;
                    if (r_ri == 2'd3) begin
                        r_idx <= 3'd0; r_de <= '0; r_state <= S_COS;
                    end else r_state <= S_RD;
                end
                S_COS: r_state <= S_COSW;
                S_COSW: begin
                    if (cos_done) begin
                        r_de <= r_idx[2] ? r_de - 20'(cos_val) : r_de + 20'(cos_val);
                        r_idx <= r_idx + 1'b1;
                        r_state <= (r_idx == 3'd7) ? S_DE : S_COS;
                    end
                end
                S_DE: begin
                    if (r_de <= 0) begin r_acc <= 1'b1; r_idx <= 3'd0; r_state <= S_WB; end
                    else r_state <= S_Y;
                end
                S_Y: begin r_y <= mprod[33:0]; r_state <= S_T; end
                S_T: begin
                    r_t <= 48'(mprod >> 15);
                    r_state <= S_G;
                end
                S_G: begin
                    if (r_t[47:22] >= 26'd17) begin
                        r_acc <= (r_u2 == 16'd0); r_idx <= 3'd0; r_state <= S_WB;
                    end else begin
                        r_n <= r_t[26:22];
                        r_g <= 17'(mprod >> 16);
                        r_p <= 17'd65536;
                        r_k <= 3'd6;
                        r_state <= S_EXPM;
                    end
                end
                S_EXPM: begin
                    r_num <= mprod[33:0];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // quotient of num / (k*65536) by reciprocal multiplication
                    r_p <= 17'd65536 - 17'(mprod >> 20);
                    r_k <= r_k - 1'b1;
                    r_state <= (r_k == 3'd1) ? S_EXPE : S_EXPM;
                end
                S_EXPE: begin
                    r_acc <= (17'(r_p >> r_n) >= {1'b0, r_u2});
                    r_idx <= 3'd0;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_idx <= r_idx + 1'b1;
                    if (!r_acc || r_idx == 3'd3) begin r_ri <= 2'd0; r_state <= S_CRD; end
                end
                S_CRD: r_state <= S_CRDW;
                S_CRDW: begin
                    unique case (r_ri)
                        2'd0: begin r_rd_e <= rd_e; r_rd_s <= rd_s; end
                        2'd1: r_phase <= sx(r_rd_s) - sx(r_rd_e) + sx(rd_e);
                        default: r_phase <= r_phase - sx(rd_s);
                    endcase
                    r_ri <= r_ri + 1'b1;
                    r_state <= (r_ri == 2'd2) ? S_CH : S_CRD;
                end
                S_CH: begin
                    r_ch <= ((AB+35)'(r_phase) <<< 16) + ((AB+35)'({1'b0, r_fill}) <<< AB);
                    r_mi <= 3'd0;
                    r_state <= S_MATCH;
                end
                S_MATCH: begin
                    if (dlt > -tolw && dlt < tolw) begin
                        o_charge <= 3'(r_mi - 3'd2);
                        o_charge_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_mi == 3'd5) begin
                        o_charge <= 3'sd0;
                        o_charge_valid <= 1'b0;
                        r_state <= S_OUT;
                    end else r_mi <= r_mi + 1'b1;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_accepted <= r_acc;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/xy_link_metropolis_step_top_tb.sv =====
// testbench for the xy link metropolis step block: loads and metropolis trials
// checked against a cycle-free predictor kept in a small scoreboard class
// depends on xylm_pkg and xy_link_metropolis_step_top
`timescale 1ns / 1ps
`default_nettype none
module xy_link_metropolis_step_top_tb;

    typedef struct packed {
        logic              accepted;
        logic signed [2:0] charge;
        logic              charge_valid;
    } t_trial_result;

    // predictor of link state, register settings and pending trial outcomes
    class t_link_scoreboard;
        bit [15:0] beta, step_scale, filling, tolerance;
        bit [15:0] east_mem [xylm_pkg::CELLS];
        bit [15:0] south_mem [xylm_pkg::CELLS];
        t_trial_result pending [$];
        int errors;

        function new();
            beta = 16'd2560;
            step_scale = 16'd6554;
            filling = 16'd240;
            tolerance = 16'd66;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic [1:0] idx, bit [15:0] v);
            case (idx)
                xylm_pkg::REG_BETA: beta = v;
                xylm_pkg::REG_STEP: step_scale = v;
                xylm_pkg::REG_FILL: filling = v;
                xylm_pkg::REG_TOL:  tolerance = v;
                default: ;
            endcase
        endfunction

        // quarter-turn cosine polynomial, q1.14
        function int quarter_cos(int u);
            int w, p;
            w = (u * u) >>> 14;
            p = 15;
            p = 342 - ((p * w) >>> 14);
            p = 4156 - ((p * w) >>> 14);
            p = 20213 - ((p * w) >>> 14);
            p = 16384 - ((p * w) >>> 14);
            return (p < 0) ? 0 : p;
        endfunction

        function int cosine(bit [15:0] a);
            int r;
            r = int'(a[13:0]);
            case (a[15:14])
                2'd0: return quarter_cos(r);
                2'd1: return -quarter_cos(16384 - r);
                2'd2: return -quarter_cos(r);
                default: return quarter_cos(16384 - r);
            endcase
        endfunction

        // exp(-beta*dE) in q16 via base-2 split and a truncated series
        function longint unsigned boltzmann(int de);
            longint unsigned y, t, n, f, g, p;
            if (de <= 0) return 65536;
            y = longint'(beta) * longint'(de);
            t = (y * 47274) >> 15;
            n = t >> 22;
            if (n >= 17) return 0;
            f = (t >> 6) & 64'hFFFF;
            g = (f * 45426) >> 16;
            p = 65536;
            for (int k = 6; k >= 1; k--)
                p = 65536 - (g * p) / (longint'(k) * 65536);
            return p >> n;
        endfunction

        function int signed_link(bit [15:0] a);
            return int'($signed(a));
        endfunction

        // accepted transaction: update state, queue the expected trial outcome
        function void note_item(bit op, bit [5:0] r, bit [5:0] c, bit [15:0] ea,
                                bit [15:0] sa, bit [15:0] u1, bit [15:0] u2);
            int here, west, north, south_c, east_c, de, phase, q;
            longint s, phi;
            bit [15:0] ph;
            bit [15:0] nv [4];
            bit [15:0] ov [4];
            bit valid, acc;
            t_trial_result res;
            here = r * xylm_pkg::GRID_COLS + c;
            if (op == xylm_pkg::OP_LOAD) begin
                east_mem[here] = ea;
                south_mem[here] = sa;
                return;
            end
            west = r * xylm_pkg::GRID_COLS
                 + ((c + xylm_pkg::GRID_COLS - 1) % xylm_pkg::GRID_COLS);
            north = ((r + xylm_pkg::GRID_ROWS - 1) % xylm_pkg::GRID_ROWS)
                  * xylm_pkg::GRID_COLS + c;
            south_c = ((r + 1) % xylm_pkg::GRID_ROWS) * xylm_pkg::GRID_COLS + c;
            east_c = r * xylm_pkg::GRID_COLS + ((c + 1) % xylm_pkg::GRID_COLS);
            s = (longint'(u1) - 32768) * longint'(step_scale);
            phi = ((s + 64'sd2147483648) >>> 16) - 32768;
            ph = phi[15:0];
            ov[0] = east_mem[here];
            ov[1] = south_mem[here];
            ov[2] = east_mem[west];
            ov[3] = south_mem[north];
            de = 0;
            for (int i = 0; i < 4; i++) begin
                nv[i] = (i < 2) ? ov[i] - ph : ov[i] + ph;
                de += cosine(ov[i]) - cosine(nv[i]);
            end
            acc = boltzmann(de) >= longint'(u2);
            if (acc) begin
                east_mem[here] = nv[0];
                south_mem[here] = nv[1];
                east_mem[west] = nv[2];
                south_mem[north] = nv[3];
            end
            // charge in units of 2^16 of one vortex
            phase = signed_link(south_mem[here]) - signed_link(east_mem[here])
                  + signed_link(east_mem[south_c]) - signed_link(south_mem[east_c])
                  + int'(filling);
            q = 0;
            valid = 0;
            for (int n = -2; n <= 3; n++) begin
                if (!valid && phase - n * 65536 > -int'(tolerance)
                        && phase - n * 65536 < int'(tolerance)) begin
                    q = n;
                    valid = 1;
                end
            end
            res.accepted = acc;
            res.charge = q[2:0];
            res.charge_valid = valid;
            pending.push_back(res);
        endfunction

        task check_result(t_trial_result got);
            t_trial_result want;
            if (pending.size() == 0) begin
                report("result strobe with no trial outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.accepted !== want.accepted)
                report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
            if (got.charge !== want.charge)
                report($sformatf("charge %0d, want %0d", got.charge, want.charge));
            if (got.charge_valid !== want.charge_valid)
                report($sformatf("charge_valid %b, want %b",
                                 got.charge_valid, want.charge_valid));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = xylm_pkg::REG_BETA;
    logic [15:0] i_cfg_data = '0;
    logic        i_opcode = xylm_pkg::OP_LOAD;
    logic [5:0]  i_row = '0;
    logic [5:0]  i_col = '0;
    logic signed [15:0] i_east_angle = '0;
    logic signed [15:0] i_south_angle = '0;
    logic [15:0] i_step_random = '0;
    logic [15:0] i_accept_random = '0;
    logic        o_valid;
    logic        o_accepted;
    logic signed [2:0] o_charge;
    logic        o_charge_valid;

    t_link_scoreboard links = new();
    int          sender_idle = 0;
    longint      cycle_count = 0;

    // register settings per phase
    bit [15:0] beta_set [6] = '{16'd2560, 16'd0, 16'd65535, 16'd300, 16'd2560, 16'd40};
    bit [15:0] step_set [6] = '{16'd6554, 16'd65535, 16'd0, 16'd1000, 16'd20000, 16'd300};
    bit [15:0] fill_set [6] = '{16'd240, 16'd0, 16'd65535, 16'd12000, 16'd0, 16'd500};
    bit [15:0] tol_set  [6] = '{16'd66, 16'd0, 16'd65535, 16'd2000, 16'd30, 16'd400};

    xy_link_metropolis_step_top DUT (.*);

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            links.check_result('{o_accepted, o_charge, o_charge_valid});
    end

    // row or column of a trial cell: rows and cols 57..63 and 0..6, whose
    // neighbors all lie in the loaded window 56..63 and 0..7
    function automatic bit [5:0] zone();
        return 6'($urandom_range(0, 13) + 57);
    endfunction

    // one transaction: optional idle cycles, then hold start until accepted
    task automatic send(bit op, bit [5:0] r, bit [5:0] c, bit [15:0] ea,
                        bit [15:0] sa, bit [15:0] u1, bit [15:0] u2);
        while ($urandom_range(0, 99) < sender_idle) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_opcode = op;
        i_row = r;
        i_col = c;
        i_east_angle = ea;
        i_south_angle = sa;
        i_step_random = u1;
        i_accept_random = u2;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        links.note_item(op, r, c, ea, sa, u1, u2);
        @(negedge i_clk);
    endtask

    task automatic trial(bit [5:0] r, bit [5:0] c, bit [15:0] u1, bit [15:0] u2);
        send(xylm_pkg::OP_TRIAL, r, c, 16'($urandom), 16'($urandom), u1, u2);
    endtask

    // let every outstanding trial come back, then settle
    task automatic drain();
        start = 1'b0;
        while (links.pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [15:0] v);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        links.set_reg(idx, v);
    endtask

    // load a plaquette whose charge lands near vortex number n, then try its cell
    task automatic shaped_plaquette(bit [5:0] r, bit [5:0] c, int n, bit [15:0] u2);
        int target, a, b, e2, d;
        bit [5:0] rs, ce;
        rs = r + 6'd1;
        ce = c + 6'd1;
        target = n * 65536 - int'(links.filling) + int'($urandom_range(0, 40)) - 20;
        for (int tries = 0; tries < 64; tries++) begin
            a = int'($signed(16'($urandom)));
            b = int'($signed(16'($urandom)));
            e2 = int'($signed(16'($urandom)));
            d = a - b + e2 - target;
            if (d >= -32768 && d <= 32767) break;
        end
        send(xylm_pkg::OP_LOAD, r, c, b[15:0], a[15:0], 16'd0, 16'd0);
        send(xylm_pkg::OP_LOAD, rs, c, e2[15:0],
             links.south_mem[rs * xylm_pkg::GRID_COLS + c], 16'd0, 16'd0);
        send(xylm_pkg::OP_LOAD, r, ce, links.east_mem[r * xylm_pkg::GRID_COLS + ce],
             d[15:0], 16'd0, 16'd0);
        trial(r, c, 16'($urandom), u2);
    endtask

    initial begin
        int pick;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fill a window that wraps across both grid edges, so no trial reads
        // an unloaded link
        for (int k = 0; k < 256; k++)
            send(xylm_pkg::OP_LOAD, 6'(k / 16 + 56), 6'(k % 16 + 56),
                 16'($urandom), 16'($urandom), 16'd0, 16'd0);

        // directed: corners, field extremes, every charge value and a miss
        send(xylm_pkg::OP_LOAD, 6'd63, 6'd63, 16'h8000, 16'h7FFF, 16'd0, 16'd0);
        send(xylm_pkg::OP_LOAD, 6'd0, 6'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
        trial(6'd0, 6'd0, 16'h0000, 16'h0000);
        trial(6'd63, 6'd63, 16'hFFFF, 16'hFFFF);
        trial(6'd0, 6'd63, 16'h8000, 16'hFFFF);
        trial(6'd63, 6'd0, 16'h8000, 16'h0000);
        for (int n = -2; n <= 3; n++)
            shaped_plaquette(zone(), zone(), n, 16'hFFFF);
        trial(6'd6, 6'd2, 16'h1234, 16'h0001);
        drain();

        // phases through several register settings and idle patterns
        for (int phase = 0; phase < 6; phase++) begin
            sender_idle = (phase < 2) ? 24 : (phase < 4) ? 53 : 0;
            write_reg(xylm_pkg::REG_BETA, beta_set[phase]);
            write_reg(xylm_pkg::REG_STEP, step_set[phase]);
            write_reg(xylm_pkg::REG_FILL, fill_set[phase]);
            write_reg(xylm_pkg::REG_TOL, tol_set[phase]);
            for (int k = 0; k < 33; k++) begin
                pick = int'($urandom_range(0, 9));
                if (pick < 5)
                    shaped_plaquette(zone(), zone(), int'($urandom_range(0, 5)) - 2,
                                     16'($urandom));
                else if (pick < 8)
                    trial(zone(), zone(), 16'($urandom), 16'($urandom));
                else
                    send(xylm_pkg::OP_LOAD, 6'($urandom), 6'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
            end
            drain();
        end

        if (links.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
